@@ src/cpa_pkg.sv @@
// ----------------------------------------------------------------------------
// cpa_pkg
// Types, codes and widths shared by the cell pedestal accumulator modules.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int SUM_W = 44;
  localparam int SQ_W  = 56;
  localparam int CNT_W = 32;
  localparam int MEM_W = SUM_W + SQ_W + CNT_W;
  localparam int POS_W = 11;

  typedef enum logic [1:0] {
    ACT_HEADER = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_EVNUM  = 2'd1,
    CAUSE_TIMING = 2'd2
  } cause_e;

  typedef enum logic [2:0] {
    CFG_TIMING_EN  = 3'd0,
    CFG_PERIOD     = 3'd1,
    CFG_MIN_EVENT  = 3'd2,
    CFG_WIN_START  = 3'd3,
    CFG_WIN_MARGIN = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HDR,
    ST_SDIV,
    ST_SADDR,
    ST_SRD,
    ST_SWR,
    ST_RRD,
    ST_ROUT
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] clock_count;
    logic [31:0] event_number;
    logic [10:0] samples_in_event;
    logic [3:0]  channel;
    logic [9:0]  position;
    logic [9:0]  stop_cell;
    logic [11:0] sample_value;
    logic [9:0]  read_cell;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic             event_accepted;
    logic [1:0]       reject_cause;
    logic [SUM_W-1:0] cell_sum;
    logic [SQ_W-1:0]  cell_sum_squares;
    logic [CNT_W-1:0] cell_count;
    logic             cell_empty;
  } result_t;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic hdr;
    logic sdiv;
    logic saddr;
    logic mem_rd;
    logic rd_sample;
    logic s_wr;
    logic r_out;
  } cmd_t;

  typedef struct packed {
    logic win_ok;
    logic clr_last;
  } stat_t;

endpackage

@@ src/cell_pedestal_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// cell_pedestal_accumulator_top
// Per-channel, per-cell pedestal sum, sum of squares and count accumulator.
// ----------------------------------------------------------------------------
// After reset the block clears its statistics store, one entry a cycle, and
// holds busy high until the clearing pass is done; configuration writes are
// taken throughout. An item is taken when start is high and busy low. A
// header goes through the header check state and its status is registered
// onto the result port; a sample goes through the divide and cell address
// steps, then the read-modify-write of the single-port-per-side store, which
// is skipped if it falls outside the window or the event was rejected; a read
// goes through the store read and output states. Each result is shown for
// exactly one cycle with result_valid_o and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module cell_pedestal_accumulator_top import cpa_pkg::*; #(
  parameter int CHANNELS    = 16,
  parameter int CELLS       = 1024,
  parameter int SAMPLE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output result_t     result_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  cpa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (in_item_i.action),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  cpa_dp #(
    .CHANNELS    (CHANNELS),
    .CELLS       (CELLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_item_i      (in_item_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  a_header_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_item_i.action == ACT_HEADER)
      |=> ##1 (result_valid_o && !result_o.result_kind))
    else $error("header item gave no status");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_item_i.action == ACT_READ)
      |=> ##2 (result_valid_o && result_o.result_kind))
    else $error("read item gave no data");

  a_status_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.result_kind)
      |-> (result_o.event_accepted == (result_o.reject_cause == CAUSE_NONE)))
    else $error("accept flag disagrees with reject cause");

endmodule

@@ src/cpa_ram.sv @@
// ----------------------------------------------------------------------------
// cpa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/cpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer: clearing pass, header check, sample read-modify-write, read.
// ----------------------------------------------------------------------------
module cpa_ctrl import cpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] action_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          unique case (action_i)
            ACT_HEADER: state_d = ST_HDR;
            ACT_SAMPLE: state_d = ST_SDIV;
            ACT_READ:   state_d = ST_RRD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_HDR: begin
        cmd_o.hdr = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_SDIV: begin
        cmd_o.sdiv = 1'b1;
        state_d    = ST_SADDR;
      end
      ST_SADDR: begin
        cmd_o.saddr = 1'b1;
        state_d     = stat_i.win_ok ? ST_SRD : ST_IDLE;
      end
      ST_SRD: begin
        cmd_o.mem_rd    = 1'b1;
        cmd_o.rd_sample = 1'b1;
        state_d         = ST_SWR;
      end
      ST_SWR: begin
        cmd_o.s_wr = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_RRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_ROUT;
      end
      ST_ROUT: begin
        cmd_o.r_out = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

@@ src/cpa_dp.sv @@
// ----------------------------------------------------------------------------
// cpa_dp
// Datapath: registers, header check, cell address, statistics store.
// ----------------------------------------------------------------------------
module cpa_dp import cpa_pkg::*; #(
  parameter int CHANNELS    = 16,
  parameter int CELLS       = 1024,
  parameter int SAMPLE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  in_item_t    in_item_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output result_t     result_o
);

  localparam int DEPTH  = CHANNELS * CELLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int CLW    = $clog2(CELLS);
  localparam int MK     = POS_W + CLW;
  localparam int MRECIP = ((1 << MK) + CELLS - 1) / CELLS;
  localparam int MW     = $clog2(MRECIP + 1);
  localparam int PW     = POS_W + MW;
  localparam logic [11:0] VAL_MASK = 12'((1 << SAMPLE_BITS) - 1);

  // configuration
  logic        tim_en_q;
  logic [31:0] period_q;
  logic [31:0] min_ev_q;
  logic [9:0]  win_start_q;
  logic [9:0]  win_margin_q;

  // event state
  logic [47:0]      prev_clk_q;
  logic             have_prev_q;
  logic             cur_acc_q;
  logic [10:0]      cur_cnt_q;

  in_item_t         in_q;
  logic [POS_W-1:0] quot_q;
  logic [23:0]      sq_q;
  logic             win_ok_q;
  logic [AW-1:0]    addr_q;
  logic [AW-1:0]    clr_addr_q;
  logic             rd_ok_q;
  logic             res_valid_q;
  result_t          res_q;

  logic [11:0]      val;
  logic [POS_W-1:0] pos_sum;
  logic [PW-1:0]    prod;
  logic [POS_W-1:0] rem;
  logic [AW-1:0]    samp_addr;
  logic [AW-1:0]    read_addr;
  logic             win_ok;
  logic [47:0]      interval;
  logic [34:0]      thr;
  logic [1:0]       cause;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [MEM_W-1:0] mem_rdata;
  logic [SUM_W-1:0] rd_sum;
  logic [SQ_W-1:0]  rd_sq;
  logic [CNT_W-1:0] rd_cnt;
  logic [SUM_W:0]   sum_add;
  logic [SQ_W:0]    sq_add;
  logic [SUM_W-1:0] new_sum;
  logic [SQ_W-1:0]  new_sq;
  logic [CNT_W-1:0] new_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tim_en_q     <= 1'b1;
      period_q     <= '0;
      min_ev_q     <= 32'd10;
      win_start_q  <= 10'd12;
      win_margin_q <= 10'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIMING_EN:  tim_en_q     <= cfg_data_i[0];
        CFG_PERIOD:     period_q     <= cfg_data_i;
        CFG_MIN_EVENT:  min_ev_q     <= cfg_data_i;
        CFG_WIN_START:  win_start_q  <= cfg_data_i[9:0];
        CFG_WIN_MARGIN: win_margin_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // header check: interval limit is period + floor(3*period/2)
  assign interval = in_q.clock_count - prev_clk_q;
  assign thr      = {2'b00, period_q, 1'b0} + 35'(period_q >> 1);

  always_comb begin
    cause = CAUSE_NONE;
    if (in_q.event_number < min_ev_q) begin
      cause = CAUSE_EVNUM;
    end else if (tim_en_q && have_prev_q && (interval > 48'(thr))) begin
      cause = CAUSE_TIMING;
    end
  end

  // sample cell: (stop + position) mod CELLS by reciprocal multiply
  assign val       = in_q.sample_value & VAL_MASK;
  assign pos_sum   = POS_W'(in_q.stop_cell) + POS_W'(in_q.position);
  assign prod      = PW'(pos_sum) * PW'(MRECIP);
  assign rem       = pos_sum - POS_W'(int'(quot_q) * CELLS);
  assign samp_addr = AW'(int'(in_q.channel) * CELLS + int'(rem));
  assign read_addr = AW'(int'(in_q.channel) * CELLS + int'(in_q.read_cell));
  assign win_ok    = cur_acc_q && (int'(in_q.channel) < CHANNELS)
                     && (in_q.position >= win_start_q)
                     && ((POS_W'(in_q.position) + POS_W'(win_margin_q)) < cur_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_clk_q  <= '0;
      have_prev_q <= 1'b0;
      cur_acc_q   <= 1'b0;
      cur_cnt_q   <= '0;
      clr_addr_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.hdr || cmd_i.r_out;
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cmd_i.hdr) begin
        prev_clk_q  <= in_q.clock_count;
        have_prev_q <= 1'b1;
        cur_acc_q   <= (cause == CAUSE_NONE);
        cur_cnt_q   <= in_q.samples_in_event;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_item_i;
    end
    if (cmd_i.sdiv) begin
      quot_q   <= POS_W'(prod >> MK);
      sq_q     <= 24'(val) * 24'(val);
      win_ok_q <= win_ok;
    end
    if (cmd_i.saddr) begin
      addr_q <= samp_addr;
    end
    if (cmd_i.mem_rd && !cmd_i.rd_sample) begin
      rd_ok_q <= (int'(in_q.channel) < CHANNELS) && (int'(in_q.read_cell) < CELLS);
    end
    if (cmd_i.hdr) begin
      res_q.result_kind      <= 1'b0;
      res_q.event_accepted   <= (cause == CAUSE_NONE);
      res_q.reject_cause     <= cause;
      res_q.cell_sum         <= '0;
      res_q.cell_sum_squares <= '0;
      res_q.cell_count       <= '0;
      res_q.cell_empty       <= 1'b0;
    end else if (cmd_i.r_out) begin
      res_q.result_kind    <= 1'b1;
      res_q.event_accepted <= 1'b0;
      res_q.reject_cause   <= CAUSE_NONE;
      res_q.cell_sum         <= rd_ok_q ? rd_sum : '0;
      res_q.cell_sum_squares <= rd_ok_q ? rd_sq : '0;
      res_q.cell_count       <= rd_ok_q ? rd_cnt : '0;
      res_q.cell_empty       <= !rd_ok_q || (rd_cnt == '0);
    end
  end

  // saturating update
  assign {rd_sum, rd_sq, rd_cnt} = mem_rdata;
  assign sum_add = {1'b0, rd_sum} + (SUM_W + 1)'(val);
  assign sq_add  = {1'b0, rd_sq} + (SQ_W + 1)'(sq_q);
  assign new_sum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign new_sq  = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
  assign new_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + CNT_W'(1);

  assign mem_we    = cmd_i.clr_step || cmd_i.s_wr;
  assign mem_waddr = cmd_i.clr_step ? clr_addr_q : addr_q;
  assign mem_wdata = cmd_i.clr_step ? '0 : {new_sum, new_sq, new_cnt};
  assign mem_raddr = cmd_i.rd_sample ? addr_q : read_addr;

  cpa_ram #(
    .WIDTH (MEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign stat_o.win_ok   = win_ok_q;
  assign stat_o.clr_last = (clr_addr_q == AW'(DEPTH - 1));
  assign result_valid_o  = res_valid_q;
  assign result_o        = res_q;

endmodule
